// ===== src/bcs_pkg.sv =====
// bcs_pkg: shared constants, command and interval codes, and the control/status
// structs that join the byte class set controller and datapath
// no dependencies
`default_nettype none

package bcs_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = BYTE_W + 1;

  localparam logic [COUNT_W-1:0] SET_SIZE = COUNT_W'(256);
  localparam logic [BYTE_W-1:0]  BYTE_MAX = 8'hFF;

  // command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_TEST   = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_FILL   = 3'd4;
  localparam logic [2:0] CMD_NEXT   = 3'd5;

  // interval kinds
  localparam logic [2:0] KIND_EMPTY  = 3'd0;
  localparam logic [2:0] KIND_ALL    = 3'd1;
  localparam logic [2:0] KIND_SINGLE = 3'd2;
  localparam logic [2:0] KIND_RANGE  = 3'd3;
  localparam logic [2:0] KIND_NONE   = 3'd4;

  // scan phases
  localparam logic [1:0] PH_LOW  = 2'd0;  // look for first member of a run
  localparam logic [1:0] PH_EXT  = 2'd1;  // look for end of the run
  localparam logic [1:0] PH_NEXT = 2'd2;  // look for any member after the run

  typedef struct packed {
    logic       take;   // transaction accepted this cycle
    logic       step;   // one scan word this cycle
    logic [1:0] phase;
  } ctl_t;

  typedef struct packed {
    logic needs_scan;   // accepted command must walk the set
    logic found;        // wanted bit seen in the current word
    logic at_end;       // scan position ran past the last byte
  } sts_t;

endpackage

`default_nettype wire

// ===== src/bcs_datapath.sv =====
// bcs_datapath: membership bits, member count, scan cursor, word scanner and
// the result register of the byte class set
// depends on bcs_pkg
`default_nettype none

module bcs_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [2:0]                 cmd,
  input  wire logic [bcs_pkg::BYTE_W-1:0] byte_value,
  input  wire bcs_pkg::ctl_t              ctl,
  output bcs_pkg::sts_t                   sts,
  output logic                            is_member,
  output logic [bcs_pkg::COUNT_W-1:0]     member_count,
  output logic [2:0]                      interval_kind,
  output logic [bcs_pkg::BYTE_W-1:0]      interval_low,
  output logic [bcs_pkg::BYTE_W-1:0]      interval_high,
  output logic                            final_interval
);
  import bcs_pkg::*;

  logic [255:0]         members;
  logic [255:0]         members_next;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic [COUNT_W-1:0]   cursor;
  logic [COUNT_W-1:0]   cursor_next;
  logic [COUNT_W-1:0]   pos;
  logic [COUNT_W-1:0]   pos_next;

  logic                 is_member_next;
  logic [COUNT_W-1:0]   member_count_next;
  logic [2:0]           interval_kind_next;
  logic [BYTE_W-1:0]    interval_low_next;
  logic [BYTE_W-1:0]    interval_high_next;
  logic                 final_interval_next;

  logic [7:0]           word;
  logic [7:0]           mask;
  logic [7:0]           cand;
  logic [2:0]           bit_idx;
  logic [BYTE_W-1:0]    hit_pos;
  logic [BYTE_W-1:0]    hit_prev;
  logic [COUNT_W-1:0]   word_next_pos;
  logic                 cur_bit;

  // lowest set bit of an 8-bit word
  function automatic logic [2:0] low_bit(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  always_comb begin
    word          = members[{pos[7:3], 3'b000} +: 8];
    mask          = 8'hFF << pos[2:0];
    cand          = (ctl.phase == PH_EXT) ? (~word & mask) : (word & mask);
    bit_idx       = low_bit(cand);
    hit_pos       = {pos[7:3], bit_idx};
    hit_prev      = hit_pos - 8'd1;
    word_next_pos = {pos[8:3] + 6'd1, 3'b000};
    cur_bit       = members[byte_value];

    sts.at_end     = pos[8];
    sts.found      = !pos[8] && (cand != 8'd0);
    sts.needs_scan = (cmd == CMD_NEXT) && !cursor[8] &&
                     (count != '0) && (count != SET_SIZE);
  end

  always_comb begin
    members_next        = members;
    count_next          = count;
    cursor_next         = cursor;
    pos_next            = pos;
    is_member_next      = is_member;
    member_count_next   = member_count;
    interval_kind_next  = interval_kind;
    interval_low_next   = interval_low;
    interval_high_next  = interval_high;
    final_interval_next = final_interval;

    if (ctl.take) begin
      is_member_next      = 1'b0;
      interval_kind_next  = KIND_EMPTY;
      interval_low_next   = '0;
      interval_high_next  = '0;
      final_interval_next = 1'b0;
      pos_next            = cursor;
      unique case (cmd)
        CMD_INSERT: begin
          if (!cur_bit) begin
            members_next[byte_value] = 1'b1;
            count_next               = count + 9'd1;
          end
          cursor_next = '0;
        end
        CMD_REMOVE: begin
          if (cur_bit) begin
            members_next[byte_value] = 1'b0;
            count_next               = count - 9'd1;
          end
          cursor_next = '0;
        end
        CMD_TEST: begin
          is_member_next = cur_bit;
        end
        CMD_CLEAR: begin
          members_next = '0;
          count_next   = '0;
          cursor_next  = '0;
        end
        CMD_FILL: begin
          members_next = '1;
          count_next   = SET_SIZE;
          cursor_next  = '0;
        end
        CMD_NEXT: begin
          if (cursor[8]) begin
            interval_kind_next  = KIND_NONE;
            final_interval_next = 1'b1;
          end else if (count == '0) begin
            interval_kind_next  = KIND_EMPTY;
            final_interval_next = 1'b1;
            cursor_next         = SET_SIZE;
          end else if (count == SET_SIZE) begin
            interval_kind_next  = KIND_ALL;
            interval_high_next  = BYTE_MAX;
            final_interval_next = 1'b1;
            cursor_next         = SET_SIZE;
          end
        end
        default: ;
      endcase
      member_count_next = count_next;
    end else if (ctl.step) begin
      unique case (ctl.phase)
        PH_LOW: begin
          if (sts.at_end) begin
            interval_kind_next  = KIND_NONE;
            final_interval_next = 1'b1;
            cursor_next         = SET_SIZE;
          end else if (sts.found) begin
            interval_low_next = hit_pos;
            pos_next          = {1'b0, hit_pos} + 9'd1;
          end else begin
            pos_next = word_next_pos;
          end
        end
        PH_EXT: begin
          if (sts.at_end) begin
            interval_high_next  = BYTE_MAX;
            interval_kind_next  = (interval_low == BYTE_MAX) ? KIND_SINGLE : KIND_RANGE;
            final_interval_next = 1'b1;
            cursor_next         = SET_SIZE;
          end else if (sts.found) begin
            interval_high_next = hit_prev;
            interval_kind_next = (interval_low == hit_prev) ? KIND_SINGLE : KIND_RANGE;
            cursor_next        = {1'b0, hit_pos};
            // look-ahead starts at the gap, past the bits of the run
            pos_next           = {1'b0, hit_pos};
          end else begin
            pos_next = word_next_pos;
          end
        end
        PH_NEXT: begin
          if (sts.at_end) begin
            final_interval_next = 1'b1;
          end else if (!sts.found) begin
            pos_next = word_next_pos;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      members <= '0;
      count   <= '0;
      cursor  <= '0;
    end else begin
      members <= members_next;
      count   <= count_next;
      cursor  <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    pos            <= pos_next;
    is_member      <= is_member_next;
    member_count   <= member_count_next;
    interval_kind  <= interval_kind_next;
    interval_low   <= interval_low_next;
    interval_high  <= interval_high_next;
    final_interval <= final_interval_next;
  end

endmodule

`default_nettype wire

// ===== src/bcs_ctrl.sv =====
// bcs_ctrl: handshake and scan sequencer of the byte class set
// depends on bcs_pkg
`default_nettype none

module bcs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire bcs_pkg::sts_t sts,
  output bcs_pkg::ctl_t      ctl
);
  import bcs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOW  = 2'd1;
  localparam logic [1:0] S_EXT  = 2'd2;
  localparam logic [1:0] S_NEXT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       done;

  always_comb begin
    in_stall  = (state != S_IDLE) || (out_valid && out_stall);
    ctl.take  = in_valid && !in_stall;
    ctl.step  = (state != S_IDLE);
    ctl.phase = PH_LOW;
    done      = 1'b0;
    state_next = state;

    unique case (state)
      S_IDLE: begin
        if (ctl.take && sts.needs_scan) state_next = S_LOW;
      end
      S_LOW: begin
        ctl.phase = PH_LOW;
        if (sts.at_end) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else if (sts.found) begin
          state_next = S_EXT;
        end
      end
      S_EXT: begin
        ctl.phase = PH_EXT;
        if (sts.at_end) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else if (sts.found) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        ctl.phase = PH_NEXT;
        if (sts.at_end || sts.found) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if ((ctl.take && !sts.needs_scan) || done) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/byte_class_set_to_ranges.sv =====
// byte_class_set_to_ranges: 256-entry byte set with interval readout
// update/test commands: result in the cycle after the transaction, one per cycle
//   while no walk runs and the result is not stalled; next interval: answered directly
//   when no walk is needed, else by a walk of one 8-bit word per cycle (words at run edges revisited, end step)
// the result register frees the input side as soon as the result is taken
// synchronous reset empties the set and zeroes count and cursor
`default_nettype none

module byte_class_set_to_ranges (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // command channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [2:0]                 cmd,
  input  wire logic [bcs_pkg::BYTE_W-1:0] byte_value,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            is_member,
  output logic [bcs_pkg::COUNT_W-1:0]     member_count,
  output logic [2:0]                      interval_kind,
  output logic [bcs_pkg::BYTE_W-1:0]      interval_low,
  output logic [bcs_pkg::BYTE_W-1:0]      interval_high,
  output logic                            final_interval
);
  import bcs_pkg::*;

  // commands from the sequencer, status back from the scanner
  ctl_t ctl;
  sts_t sts;

  // sequencer: accepts a transaction, steps the three scan phases
  // (first member, end of run, any later member) and raises out_valid
  bcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // datapath: membership bits, count, cursor, scanner and result register
  bcs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .byte_value     (byte_value),
    .ctl            (ctl),
    .sts            (sts),
    .is_member      (is_member),
    .member_count   (member_count),
    .interval_kind  (interval_kind),
    .interval_low   (interval_low),
    .interval_high  (interval_high),
    .final_interval (final_interval)
  );

endmodule

`default_nettype wire

// ===== src/bcs_checker.sv =====
// bcs_checker: port-level checks of byte_class_set_to_ranges, bound to the top
// depends on bcs_pkg
`default_nettype none

module bcs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       is_member,
  input wire logic [8:0] member_count,
  input wire logic [2:0] interval_kind,
  input wire logic [7:0] interval_low,
  input wire logic [7:0] interval_high,
  input wire logic       final_interval
);
  import bcs_pkg::*;

  // stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its count and interval fields
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(member_count) && $stable(interval_kind) &&
      $stable(interval_low) && $stable(interval_high) && $stable(final_interval))
    else $error("result changed while stalled");

  // count never exceeds the set size and a member implies a non-empty set
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (member_count <= SET_SIZE) && (!is_member || (member_count != 9'd0)))
    else $error("member count inconsistent");

  // single byte has equal bounds, range has ascending bounds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (interval_kind == KIND_SINGLE || interval_kind == KIND_RANGE) |->
      ((interval_kind == KIND_SINGLE) ? (interval_low == interval_high)
                                      : (interval_low < interval_high)))
    else $error("interval bounds wrong");

  // exhausted walk and all-bytes answer are always the last interval
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (interval_kind == KIND_NONE || interval_kind == KIND_ALL) |->
      final_interval)
    else $error("terminal interval not flagged final");

endmodule

bind byte_class_set_to_ranges bcs_checker u_bcs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .is_member      (is_member),
  .member_count   (member_count),
  .interval_kind  (interval_kind),
  .interval_low   (interval_low),
  .interval_high  (interval_high),
  .final_interval (final_interval)
);

`default_nettype wire
